### src/msrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msrr_pkg;

	// sensor lines on the ports
	localparam int LINE_COUNT = 6;
	localparam int SENSOR_COUNT_DEF = 6;

	localparam int PERIOD_W = 20;
	localparam int TIMEOUT_W = 16;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_INDEX_W = 1;
	localparam int SENSOR_W = 3;
	localparam int WIDTH_W = 16;
	localparam int DIST_W = 15;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_PING_PERIOD = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ECHO_TIMEOUT = 1'd1;

	localparam logic [PERIOD_W-1:0] PING_PERIOD_RST = 20'd50000;
	localparam logic [TIMEOUT_W-1:0] ECHO_TIMEOUT_RST = 16'd30000;

	localparam logic [WIDTH_W-1:0] TRIG_LOW_TICKS = 16'd2;
	localparam logic [WIDTH_W-1:0] TRIG_HIGH_TICKS = 16'd10;

	// width*16/58 == (width*8)/29, reciprocal exact for operands below 2^20
	localparam int DIST_X_W = WIDTH_W + 3;
	localparam int DIST_RECIP_W = 21;
	localparam logic [DIST_RECIP_W-1:0] DIST_RECIP = 21'd1157050;
	localparam int DIST_SHIFT = 25;

endpackage

`default_nettype wire

### src/msrr_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface msrr_echo_if;
	logic valid;
	logic ready;
	logic [msrr_pkg::LINE_COUNT-1:0] echo_levels;

	modport source(output valid, output echo_levels, input ready);
	modport sink(input valid, input echo_levels, output ready);
endinterface

interface msrr_reading_if;
	logic valid;
	logic ready;
	logic [msrr_pkg::LINE_COUNT-1:0] trigger_lines;
	logic reading_valid;
	logic [msrr_pkg::SENSOR_W-1:0] reading_sensor;
	logic no_echo;
	logic [msrr_pkg::DIST_W-1:0] distance_q4_cm;
	logic [msrr_pkg::WIDTH_W-1:0] echo_width_us;

	modport source(output valid, output trigger_lines, output reading_valid,
		output reading_sensor, output no_echo, output distance_q4_cm,
		output echo_width_us, input ready);
	modport sink(input valid, input trigger_lines, input reading_valid,
		input reading_sensor, input no_echo, input distance_q4_cm,
		input echo_width_us, output ready);
endinterface

`default_nettype wire

### src/multi_sonar_round_robin_ranger.sv
`timescale 1ns / 1ps
`default_nettype none

// round-robin controller for up to SENSOR_COUNT ultrasonic rangers
// echo: one request per microsecond tick, carrying the sampled echo line levels
// reading: exactly one request per accepted tick, carrying the trigger line levels
//   for that tick and, on the tick a measurement ends, the reading (sensor, no_echo,
//   echo width in us, distance in cm with four fraction bits)
// cfg_we/cfg_index/cfg_data: register 0 is the ping period, register 1 the echo
//   timeout; write them only while no tick is in flight
// throughput: one tick per clock cycle while not stalled, the whole state update for a
//   tick is one pass of logic between the state registers and the first pipeline stage
// pipeline: the result of a tick is registered in the first and then the second stage
//   before it is offered; the second stage does the constant multiply for the distance
// stall: when the receiver holds ready low while a result is offered, both stages hold
//   and echo.ready drops in the same cycle, so nothing is lost or repeated
// reset: sensor 0 active, idle, ping period 50000 us, echo timeout 30000 us;
//   the first ping starts once the ping period has gone by

module multi_sonar_round_robin_ranger #(
	parameter int SENSOR_COUNT = msrr_pkg::SENSOR_COUNT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	msrr_echo_if.sink echo,
	msrr_reading_if.source reading,
	input wire logic cfg_we,
	input wire logic [msrr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [msrr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ACT_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam int EXT_W = ACT_W + msrr_pkg::SENSOR_W;
	localparam int LW = msrr_pkg::LINE_COUNT;
	localparam int CW = msrr_pkg::WIDTH_W;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TRIG_LOW,
		PH_TRIG_HIGH,
		PH_WAIT_RISE,
		PH_WAIT_FALL
	} phase_t;

	phase_t phase_q, phase_d;
	logic [msrr_pkg::PERIOD_W-1:0] ping_period_q;
	logic [msrr_pkg::TIMEOUT_W-1:0] echo_timeout_q;
	logic [msrr_pkg::PERIOD_W-1:0] since_q, since_d;
	logic [CW-1:0] pc_q, pc_d;
	logic [ACT_W-1:0] active_q, active_d;

	logic v_s1, v_s2;
	logic [LW-1:0] trig_s1, trig_s2;
	logic rv_s1, rv_s2;
	logic [msrr_pkg::SENSOR_W-1:0] sensor_s1, sensor_s2;
	logic noecho_s1, noecho_s2;
	logic [CW-1:0] width_s1, width_s2;
	logic [msrr_pkg::DIST_W-1:0] dist_s2;

	logic en, acc;
	logic [EXT_W-1:0] sensor_ext;
	logic [msrr_pkg::SENSOR_W-1:0] sensor_lo;
	logic in_range, echo_bit;
	logic [CW:0] n;
	logic fin, timed_out;
	logic [LW-1:0] trig_d;
	logic [CW-1:0] width_d;
	logic [ACT_W-1:0] active_next;
	logic [msrr_pkg::DIST_X_W-1:0] dist_x;
	logic [msrr_pkg::DIST_X_W+msrr_pkg::DIST_RECIP_W-1:0] dist_prod;

	// whole pipe moves when the output stage is empty or being taken
	assign en = !v_s2 || reading.ready;
	assign echo.ready = en;
	assign acc = echo.valid && en;

	assign sensor_ext = {{msrr_pkg::SENSOR_W{1'b0}}, active_q};
	assign sensor_lo = sensor_ext[msrr_pkg::SENSOR_W-1:0];
	assign in_range = sensor_ext < EXT_W'(LW);
	assign echo_bit = in_range && echo.echo_levels[sensor_lo];
	assign n = {1'b0, pc_q} + (CW+1)'(1);
	assign active_next = (active_q == ACT_W'(SENSOR_COUNT - 1)) ? '0 : active_q + ACT_W'(1);

	always_comb begin
		phase_d = phase_q;
		since_d = since_q;
		pc_d = pc_q;
		active_d = active_q;
		fin = 1'b0;
		timed_out = 1'b0;
		trig_d = '0;
		if (phase_q == PH_IDLE && since_q >= ping_period_q) begin
			since_d = '0;
			phase_d = PH_TRIG_LOW;
			pc_d = CW'(1);
		end else begin
			if (since_q != '1) begin
				since_d = since_q + msrr_pkg::PERIOD_W'(1);
			end
			case (phase_q)
				PH_TRIG_LOW: begin
					pc_d = n[CW-1:0];
					if (n[CW-1:0] >= msrr_pkg::TRIG_LOW_TICKS) begin
						phase_d = PH_TRIG_HIGH;
						pc_d = '0;
					end
				end
				PH_TRIG_HIGH: begin
					if (in_range) begin
						trig_d = LW'(1) << sensor_lo;
					end
					pc_d = n[CW-1:0];
					if (n[CW-1:0] >= msrr_pkg::TRIG_HIGH_TICKS) begin
						phase_d = PH_WAIT_RISE;
						pc_d = '0;
					end
				end
				PH_WAIT_RISE: begin
					if (echo_bit) begin
						phase_d = PH_WAIT_FALL;
						pc_d = '0;
					end else if (n > {1'b0, echo_timeout_q}) begin
						fin = 1'b1;
						timed_out = 1'b1;
					end else begin
						pc_d = n[CW-1:0];
					end
				end
				PH_WAIT_FALL: begin
					// the fall wins over the timeout on the same tick
					if (!echo_bit) begin
						fin = 1'b1;
					end else if (n > {1'b0, echo_timeout_q}) begin
						fin = 1'b1;
						timed_out = 1'b1;
					end else begin
						pc_d = n[CW-1:0];
					end
				end
				default: begin
					phase_d = PH_IDLE;
					pc_d = '0;
				end
			endcase
			if (fin) begin
				active_d = active_next;
				phase_d = PH_IDLE;
				pc_d = '0;
			end
		end
	end

	// a width of 65536 can only come with the largest timeout, it saturates
	assign width_d = (fin && !timed_out) ? (n[CW] ? '1 : n[CW-1:0]) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_period_q <= msrr_pkg::PING_PERIOD_RST;
			echo_timeout_q <= msrr_pkg::ECHO_TIMEOUT_RST;
			phase_q <= PH_IDLE;
			since_q <= '0;
			pc_q <= '0;
			active_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					msrr_pkg::REG_PING_PERIOD: ping_period_q <= cfg_data;
					msrr_pkg::REG_ECHO_TIMEOUT:
						echo_timeout_q <= cfg_data[msrr_pkg::TIMEOUT_W-1:0];
					default: ;
				endcase
			end
			if (en) begin
				v_s1 <= echo.valid;
			end
			if (acc) begin
				phase_q <= phase_d;
				since_q <= since_d;
				pc_q <= pc_d;
				active_q <= active_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			trig_s1 <= trig_d;
			rv_s1 <= fin;
			sensor_s1 <= fin ? sensor_lo : '0;
			noecho_s1 <= fin && timed_out;
			width_s1 <= width_d;
		end
	end

	assign dist_x = {width_s1, 3'b000};
	assign dist_prod = dist_x * msrr_pkg::DIST_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			trig_s2 <= trig_s1;
			rv_s2 <= rv_s1;
			sensor_s2 <= sensor_s1;
			noecho_s2 <= noecho_s1;
			width_s2 <= width_s1;
			dist_s2 <= dist_prod[msrr_pkg::DIST_SHIFT +: msrr_pkg::DIST_W];
		end
	end

	assign reading.valid = v_s2;
	assign reading.trigger_lines = trig_s2;
	assign reading.reading_valid = rv_s2;
	assign reading.reading_sensor = sensor_s2;
	assign reading.no_echo = noecho_s2;
	assign reading.distance_q4_cm = dist_s2;
	assign reading.echo_width_us = width_s2;

	a_active_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= ACT_W'(SENSOR_COUNT - 1))
		else $error("active sensor out of range");

	a_trig_low_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TRIG_LOW |-> pc_q < msrr_pkg::TRIG_LOW_TICKS)
		else $error("trigger low phase overran");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && fin) |=> (phase_q == PH_IDLE && pc_q == '0))
		else $error("finished measurement did not return to idle");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(reading.valid && reading.no_echo) |->
		(reading.reading_valid && reading.echo_width_us == '0 &&
		reading.distance_q4_cm == '0))
		else $error("timeout reading carries a width or distance");

	a_trig_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && trig_d != '0) |-> (phase_q == PH_TRIG_HIGH && $onehot(trig_d)))
		else $error("trigger driven outside the trigger high phase");

endmodule

`default_nettype wire
